>>> rtl/s2xyz_pkg.sv
// ----------------------------------------------------------------------------
// s2xyz_pkg: constants, types and build-time tables for sRGB to XYZ (D65)
// Holds the Q1.30 gamma-expansion table and the Q0.30 matrix coefficients,
// both computed during elaboration by constant functions.
// ----------------------------------------------------------------------------
package s2xyz_pkg;

  // Fixed field widths
  localparam int CODE_W      = 8;
  localparam int CODES       = 1 << CODE_W;
  localparam int FRAC_BITS   = 16;
  localparam int OUT_W       = FRAC_BITS + 1;
  localparam int IN_TDATA_W  = ((3 * CODE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  // Internal fixed-point formats
  localparam int LIN_BITS = 30;
  localparam int LIN_W    = LIN_BITS + 1;          // entry for code 255 is 1.0
  localparam int COEF_W   = LIN_BITS;
  localparam int PROD_W   = LIN_W + COEF_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int RND_SH   = 2 * LIN_BITS - FRAC_BITS;

  localparam logic [63:0] ONE_Q30  = 64'd1 << LIN_BITS;
  localparam logic [63:0] HALF_Q30 = 64'd1 << (LIN_BITS - 1);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [OUT_W-1:0]  tri_t;

  typedef lin_t  lin_tab_t [CODES];
  typedef coef_t coef_arr_t [9];

  // Matrix coefficients scaled by 1e16, row-major (X, Y, Z rows)
  localparam logic [63:0] COEF_DEC [9] = '{
    64'd4123865632529917, 64'd3575914909206254, 64'd1804504912035637,
    64'd2126368216773238, 64'd7151829818412507, 64'd721801964814255,
    64'd193306201524840,  64'd1191971636402085, 64'd9503725870054354
  };

  // Round-half-up of c * 2^30 / 1e16
  function automatic logic [63:0] dec_to_q30(input logic [63:0] c);
    logic [63:0] hi, lo, a, q, r;
    hi = c / 64'd100000000;
    lo = c % 64'd100000000;
    a  = hi << LIN_BITS;
    q  = a / 64'd100000000;
    r  = a % 64'd100000000;
    return q + (r * 64'd100000000 + (lo << LIN_BITS) + 64'd5000000000000000)
               / 64'd10000000000000000;
  endfunction

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_Q30) >> LIN_BITS;
  endfunction

  function automatic logic [63:0] pow5_q30(input logic [63:0] r);
    logic [63:0] r2, r4;
    r2 = mul_q30(r, r);
    r4 = mul_q30(r2, r2);
    return mul_q30(r4, r);
  endfunction

  // Linear-light value of one 8-bit code, Q1.30
  function automatic logic [63:0] expand_code(input logic [63:0] code);
    logic [63:0] b, s, lo, hi, mid;
    lo = 64'd0;
    hi = ONE_Q30;
    if (code <= 64'd10) begin
      return (64'd5 * code * ONE_Q30 + 64'd8236) / 64'd16473;
    end
    b = ((64'd1000 * code + 64'd14025) * ONE_Q30 + 64'd134512) / 64'd269025;
    s = mul_q30(b, b);
    // fifth root of s by bisection
    for (int k = 0; k < 40; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return mul_q30(s, lo);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t t;
    for (int i = 0; i < CODES; i++) begin
      t[i] = LIN_W'(expand_code(64'(i)));
    end
    return t;
  endfunction

  function automatic coef_arr_t build_coef();
    coef_arr_t c;
    for (int i = 0; i < 9; i++) begin
      c[i] = COEF_W'(dec_to_q30(COEF_DEC[i]));
    end
    return c;
  endfunction

  localparam lin_tab_t  LIN_TAB = build_lin_tab();
  localparam coef_arr_t COEF    = build_coef();

endpackage

>>> rtl/srgb_to_xyz_d65.sv
// ----------------------------------------------------------------------------
// srgb_to_xyz_d65: sRGB pixel to CIE XYZ (D65) converter
// Gamma expansion by constant table, 3x3 matrix, round to unsigned Q1.16.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals            Payload
//  in_      in   tvalid/tready      tdata: red, green, blue (8b each)
//  out_     out  tvalid/tready      tdata: tri_x, tri_y, tri_z (17b each)
//
//  One pixel per clock sustained while out_tready stays high. Four register
//  stages: input, table lookup, products, rounded sum; out_tvalid rises once
//  a pixel has passed through all four. Each stage holds while the stage
//  after it is full and stalled, so empty stages keep taking transactions
//  under backpressure. rst_n clears the stage valid bits only.
// ----------------------------------------------------------------------------
module srgb_to_xyz_d65 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [s2xyz_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [16:0] tri_x, [33:17] tri_y, [50:34] tri_z, [55:51] zero
  output logic [s2xyz_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import s2xyz_pkg::*;

  logic  v1_r, v2_r, v3_r, v4_r;
  logic  rdy1, rdy2, rdy3, rdy4;
  code_t code_r [3];
  lin_t  lin_r  [3];
  prod_t prod_r [3][3];
  prod_t prod_nxt [3][3];
  tri_t  tri_r  [3];
  tri_t  tri_nxt [3];
  sum_t  sum_v  [3];

  // Stage ready chain: a stage loads when empty or when it drains this cycle
  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // Matrix products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = PROD_W'(COEF[r*3 + c]) * PROD_W'(lin_r[c]);
      end
    end
  end

  // Row sums, round half up to Q1.FRAC_BITS
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_v[r] = SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]) + SUM_W'(prod_r[r][2])
                 + (SUM_W'(1) << (RND_SH - 1));
      tri_nxt[r] = sum_v[r][RND_SH +: OUT_W];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      for (int c = 0; c < 3; c++) begin
        code_r[c] <= in_tdata[c*CODE_W +: CODE_W];
      end
    end
    if (rdy2 && v1_r) begin
      for (int c = 0; c < 3; c++) begin
        lin_r[c] <= LIN_TAB[code_r[c]];
      end
    end
    if (rdy3 && v2_r) begin
      prod_r <= prod_nxt;
    end
    if (rdy4 && v3_r) begin
      tri_r <= tri_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = OUT_TDATA_W'({tri_r[2], tri_r[1], tri_r[0]});

endmodule
